[hw/rtl/dsse_pkg.sv]
// dsse_pkg: shared types, constants and segment table for the decimal
// seven-segment encoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dsse_pkg;

    localparam int VALUE_W = 20;
    localparam int POS_W   = 3;
    localparam int SEG_W   = 8;
    localparam int DP_W    = 3;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    // register map
    localparam logic [ADDR_W-1:0] REG_DP_ADDR = 3'd0;
    localparam logic [DP_W-1:0]   DP_RESET    = 3'd2;

    // reciprocal of ten for a 20-bit dividend: q = (t * RECIP10) >> RECIP_SH
    localparam logic [VALUE_W-1:0] RECIP10  = 20'd838861;
    localparam int                 RECIP_SH = 23;

    // powers of ten used for the digit count
    localparam logic [31:0] POW10 [0:9] = '{
        32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
        32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
    };

    // one accepted value, ready for the emitter
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   nblank;
        logic [DP_W-1:0]    dp;
    } item_t;

    function automatic logic [SEG_W-1:0] seg_lo(input logic [3:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 8'hFC;
            4'd1:    s = 8'h60;
            4'd2:    s = 8'hDB;
            4'd3:    s = 8'hF3;
            4'd4:    s = 8'h67;
            4'd5:    s = 8'hB7;
            4'd6:    s = 8'hBF;
            4'd7:    s = 8'hE4;
            4'd8:    s = 8'hFF;
            4'd9:    s = 8'hF7;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    function automatic logic [SEG_W-1:0] seg_hi(input logic [3:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 8'h28;
            4'd1:    s = 8'h20;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/dsse_in_stage.sv]
// dsse_in_stage: input register; captures a value, its blank count and the
// effective decimal point. Depends on dsse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsse_in_stage #(
    parameter int NUM_DIGITS = 6
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [dsse_pkg::VALUE_W-1:0] value,
    input  wire logic [dsse_pkg::DP_W-1:0]    dp_cfg,
    input  wire logic                        take,
    output logic                             item_valid,
    output dsse_pkg::item_t                  item
);
    import dsse_pkg::*;

    localparam int NW = $clog2(NUM_DIGITS + 1);

    logic            valid_reg;
    logic            valid_next;
    item_t           item_reg;
    item_t           item_next;
    logic [NW-1:0]   ndig;
    logic [DP_W-1:0] dp_eff;
    logic            accept;

    // digit count from magnitude, raised to reach the decimal point
    always_comb
    begin
        ndig = NW'(1);
        for (int i = 1; i < NUM_DIGITS; i++)
        begin
            if ({{(32-VALUE_W){1'b0}}, value} >= POW10[i])
                ndig = NW'(i + 1);
        end
        if ({1'b0, dp_cfg} > 4'(NUM_DIGITS - 1))
            dp_eff = '0;
        else
            dp_eff = dp_cfg;
        if (NW'(dp_eff) >= ndig)
            ndig = NW'(dp_eff) + NW'(1);
    end

    assign in_stall = valid_reg && !take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        item_next.value  = value;
        item_next.nblank = POS_W'(NW'(NUM_DIGITS) - ndig);
        item_next.dp     = dp_eff;
        if (accept)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    // control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

[hw/rtl/dsse_digit.sv]
// dsse_digit: splits off the low decimal digit by reciprocal multiply and
// maps it to its segment bytes. Depends on dsse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsse_digit (
    input  wire logic [dsse_pkg::VALUE_W-1:0] t,
    output logic [dsse_pkg::VALUE_W-1:0]      quot,
    output logic [dsse_pkg::SEG_W-1:0]        lo,
    output logic [dsse_pkg::SEG_W-1:0]        hi
);
    import dsse_pkg::*;

    logic [2*VALUE_W-1:0] prod;
    logic [VALUE_W-1:0]   rem;
    logic [3:0]           d;

    // floor(t / 10), exact for every 20-bit t
    always_comb
    begin
        prod = {{VALUE_W{1'b0}}, t} * {{VALUE_W{1'b0}}, RECIP10};
        quot = VALUE_W'(prod >> RECIP_SH);
        rem  = t - ((quot << 3) + (quot << 1));
        d    = rem[3:0];
        lo   = seg_lo(d);
        hi   = seg_hi(d);
    end

endmodule

`default_nettype wire

[hw/rtl/decimal_seven_segment_encoder.sv]
// decimal_seven_segment_encoder: top level with config register, word
// sequencer and result register. Depends on dsse_pkg, dsse_in_stage, dsse_digit.
// Each accepted value produces NUM_DIGITS words, one per cycle while out_stall is
// low. Words come out blanked positions first (top down), then digits from
// position 0 upward; last marks the final word. An input register holds the
// next value while the current one is emitted, so the words of successive
// values follow without a gap. The first word of a value accepted into an idle
// block goes through the input register, sequencer and result register in turn.
// decimal_point is sampled when a value is accepted.
`timescale 1ns / 1ps
`default_nettype none

module decimal_seven_segment_encoder #(
    parameter int NUM_DIGITS = 6
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // config port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [dsse_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [dsse_pkg::DATA_W-1:0]  pwdata,
    output logic [dsse_pkg::DATA_W-1:0]       prdata,
    output logic                              pready,
    // input channel
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [dsse_pkg::VALUE_W-1:0] value,
    // result channel
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [dsse_pkg::POS_W-1:0]        position,
    output logic [dsse_pkg::SEG_W-1:0]        low_segments,
    output logic [dsse_pkg::SEG_W-1:0]        high_segments,
    output logic                              blank,
    output logic                              last
);
    import dsse_pkg::*;

    localparam int KW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    logic [DP_W-1:0]    dp_reg;
    logic               item_valid;
    item_t              item;
    logic               take;

    logic               busy_reg, busy_next;
    logic [KW-1:0]      k_reg, k_next;
    logic [VALUE_W-1:0] t_reg, t_next;
    logic [POS_W-1:0]   nblank_reg, nblank_next;
    logic [DP_W-1:0]    wdp_reg, wdp_next;

    logic               out_valid_reg, out_valid_next;
    logic [POS_W-1:0]   position_reg, position_next;
    logic [SEG_W-1:0]   lo_reg, lo_next;
    logic [SEG_W-1:0]   hi_reg, hi_next;
    logic               blank_reg, blank_next;
    logic               last_reg, last_next;

    logic               adv;
    logic               is_blank;
    logic               is_last;
    logic [KW-1:0]      p;
    logic [VALUE_W-1:0] quot;
    logic [SEG_W-1:0]   dlo, dhi;

    // config register
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dp_reg <= DP_RESET;
        else if (psel && penable && pwrite && paddr == REG_DP_ADDR)
            dp_reg <= pwdata[DP_W-1:0];
    end

    always_comb
    begin
        if (paddr == REG_DP_ADDR)
            prdata = {{(DATA_W-DP_W){1'b0}}, dp_reg};
        else
            prdata = '0;
    end

    dsse_in_stage #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .dp_cfg     (dp_reg),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    dsse_digit u_digit (
        .t    (t_reg),
        .quot (quot),
        .lo   (dlo),
        .hi   (dhi)
    );

    // word decode for the current sequencer step
    assign adv      = busy_reg && (!out_valid_reg || !out_stall);
    assign is_blank = POS_W'(k_reg) < nblank_reg;
    assign is_last  = k_reg == KW'(NUM_DIGITS - 1);
    assign p        = k_reg - KW'(nblank_reg);
    assign take     = item_valid && (!busy_reg || (adv && is_last));

    always_comb
    begin
        position_next = position_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        blank_next    = blank_reg;
        last_next     = last_reg;
        if (is_blank)
        begin
            position_next = POS_W'(KW'(NUM_DIGITS - 1) - k_reg);
            lo_next       = '0;
            hi_next       = '0;
            blank_next    = 1'b1;
        end
        else
        begin
            position_next = POS_W'(p);
            lo_next       = dlo;
            hi_next       = dhi;
            if (p != '0)
                hi_next[0] = (POS_W'(p) == wdp_reg);
            blank_next    = 1'b0;
        end
        last_next = is_last;
    end

    // sequencer next state
    always_comb
    begin
        busy_next   = busy_reg;
        k_next      = k_reg;
        t_next      = t_reg;
        nblank_next = nblank_reg;
        wdp_next    = wdp_reg;
        if (adv)
        begin
            k_next = k_reg + KW'(1);
            if (!is_blank)
                t_next = quot;
            if (is_last)
                busy_next = 1'b0;
        end
        if (take)
        begin
            busy_next   = 1'b1;
            k_next      = '0;
            t_next      = item.value;
            nblank_next = item.nblank;
            wdp_next    = item.dp;
        end
        if (adv)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working value and result word
    always_ff @(posedge clk)
    begin
        t_reg      <= t_next;
        nblank_reg <= nblank_next;
        wdp_reg    <= wdp_next;
        if (adv)
        begin
            position_reg <= position_next;
            lo_reg       <= lo_next;
            hi_reg       <= hi_next;
            blank_reg    <= blank_next;
            last_reg     <= last_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign position      = position_reg;
    assign low_segments  = lo_reg;
    assign high_segments = hi_reg;
    assign blank         = blank_reg;
    assign last          = last_reg;

endmodule

`default_nettype wire

[tb/tb.sv]
// tb: self-checking bench for decimal_seven_segment_encoder, random and directed
// values under several decimal point settings. Depends on dsse_pkg and the block.
`timescale 1ns / 1ps

module tb;

    import dsse_pkg::*;

    localparam int DIGITS      = 6;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 60;
    localparam int IDLE_PCT    = 26;
    localparam int MAX_SHOWN   = 10;

    // segment bytes per decimal digit
    localparam logic [SEG_W-1:0] DIGIT_LO [0:9] = '{
        8'hFC, 8'h60, 8'hDB, 8'hF3, 8'h67, 8'hB7, 8'hBF, 8'hE4, 8'hFF, 8'hF7
    };
    localparam logic [SEG_W-1:0] DIGIT_HI [0:9] = '{
        8'h28, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [SEG_W-1:0] low_seg;
        logic [SEG_W-1:0] high_seg;
        logic             blank;
        logic             last;
    } disp_word_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [DATA_W-1:0]    pwdata = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [VALUE_W-1:0]   value = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [POS_W-1:0]     position;
    logic [SEG_W-1:0]     low_segments;
    logic [SEG_W-1:0]     high_segments;
    logic                 blank;
    logic                 last;

    logic [VALUE_W-1:0]   pending_values [$];
    disp_word_t           display_words_q [$];
    logic [DP_W-1:0]      dp_cfg = DP_RESET;
    bit                   in_taken = 1'b0;
    bit                   calm = 1'b0;
    bit                   hold_req = 1'b0;
    int                   hold_left = 0;
    int                   values_queued = 0;
    int                   values_taken = 0;
    int                   mismatches = 0;
    int                   cycles = 0;

    decimal_seven_segment_encoder #(
        .NUM_DIGITS(DIGITS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .position      (position),
        .low_segments  (low_segments),
        .high_segments (high_segments),
        .blank         (blank),
        .last          (last)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("mismatch at cycle %0d: %s", cycles, what);
    endtask

    // expected words for one value under the current decimal point setting
    function automatic void push_display_words(input logic [VALUE_W-1:0] v);
        int unsigned rest;
        int unsigned ndig;
        int unsigned dp;
        int unsigned pos;
        int unsigned d;
        disp_word_t  w;
        rest = v;
        ndig = 1;
        while (rest >= 10 && ndig < DIGITS)
        begin
            rest = rest / 10;
            ndig++;
        end
        dp = dp_cfg;
        if (dp > DIGITS - 1)
            dp = 0;
        if (dp >= ndig)
            ndig = dp + 1;
        // unused upper positions, top down
        for (pos = DIGITS; pos > ndig; pos--)
        begin
            w.position = POS_W'(pos - 1);
            w.low_seg  = '0;
            w.high_seg = '0;
            w.blank    = 1'b1;
            w.last     = 1'b0;
            display_words_q.push_back(w);
        end
        // digits from position 0 upward
        rest = v;
        for (pos = 0; pos < ndig; pos++)
        begin
            d = rest % 10;
            rest = rest / 10;
            w.position = POS_W'(pos);
            w.low_seg  = DIGIT_LO[d];
            w.high_seg = DIGIT_HI[d];
            if (pos != 0)
                w.high_seg[0] = (pos == dp);
            w.blank    = 1'b0;
            w.last     = (pos + 1 == ndig);
            display_words_q.push_back(w);
        end
    endfunction

    // random value, mostly shaped by digit count so every length shows up
    function automatic logic [VALUE_W-1:0] random_value();
        int unsigned digits;
        int unsigned lo;
        int unsigned hi;
        int unsigned i;
        if ($urandom_range(0, 2) == 0)
            return VALUE_W'($urandom);
        digits = $urandom_range(1, 7);
        lo = 1;
        for (i = 1; i < digits; i++)
            lo = lo * 10;
        hi = lo * 10 - 1;
        if (digits == 1)
            lo = 0;
        if (hi > 1048575)
            hi = 1048575;
        return VALUE_W'($urandom_range(hi, lo));
    endfunction

    task automatic queue_value(input logic [VALUE_W-1:0] v);
        pending_values.push_back(v);
        values_queued++;
    endtask

    // register write followed by a readback
    task automatic set_decimal_point(input logic [DP_W-1:0] dp);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_DP_ADDR;
        pwdata  <= DATA_W'(dp);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        dp_cfg = dp;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[DP_W-1:0] !== dp)
            report_mismatch($sformatf("decimal_point readback exp %0d got %0d",
                                      dp, prdata[DP_W-1:0]));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // wait until every queued value is taken and every word has come back
    task automatic drain();
        while (values_taken != values_queued || display_words_q.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    // input driver: next value from the pending queue, random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (pending_values.size() != 0 &&
                (calm || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                value    <= pending_values.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
        in_taken = 1'b0;
    end

    // result side stall: random, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (hold_req)
        begin
            hold_left = HOLD_CYCLES - 1;
            hold_req  = 1'b0;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // monitor: check each word taken, predict on each value taken
    always @(posedge clk)
    begin
        disp_word_t got;
        disp_word_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = '{position, low_segments, high_segments, blank, last};
                if (display_words_q.size() == 0)
                    report_mismatch($sformatf("unexpected word pos %0d lo %h hi %h bl %b ls %b",
                                              position, low_segments, high_segments,
                                              blank, last));
                else
                begin
                    want = display_words_q.pop_front();
                    if (got !== want)
                        report_mismatch($sformatf(
                            "exp pos %0d lo %h hi %h bl %b ls %b, got pos %0d lo %h hi %h bl %b ls %b",
                            want.position, want.low_seg, want.high_seg, want.blank, want.last,
                            got.position, got.low_seg, got.high_seg, got.blank, got.last));
                end
            end
            if (in_valid && !in_stall)
            begin
                push_display_words(value);
                values_taken++;
                in_taken = 1'b1;
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // stimulus: directed values at reset setting, then one phase per setting
    initial
    begin
        logic [DP_W-1:0] dp_list [0:7];
        int ph;
        int i;
        dp_list = '{3'd0, 3'd5, 3'd7, 3'd3, 3'd6, 3'd1, 3'd4, 3'd2};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes and digit-count boundaries under the reset decimal point
        queue_value(20'd0);
        queue_value(20'd1);
        queue_value(20'd9);
        queue_value(20'd10);
        queue_value(20'd99);
        queue_value(20'd100);
        queue_value(20'd9876);
        queue_value(20'd12345);
        queue_value(20'd99999);
        queue_value(20'd100000);
        queue_value(20'd543210);
        queue_value(20'd999999);
        queue_value(20'd1000000);
        queue_value(20'd1048575);
        drain();

        for (ph = 0; ph < 8; ph++)
        begin
            set_decimal_point(dp_list[ph]);
            // long receiver hold-off while the sender keeps offering
            if (ph == 3)
                hold_req = 1'b1;
            // one phase with no idling on either side
            if (ph == 5)
                calm = 1'b1;
            queue_value(20'd0);
            queue_value(20'd1048575);
            for (i = 0; i < 10; i++)
                queue_value(random_value());
            drain();
            calm = 1'b0;
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
